/* src/rvdec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_pkg
// Opcodes, format and instruction codes, and the result layout of the
// RV32I subset decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

	localparam int unsigned InstrW = 32;
	localparam int unsigned ImmW   = 21;
	localparam int unsigned ResW   = 44;
	localparam int unsigned OutW   = 48;

	localparam logic [6:0] OPC_REG    = 7'b0110011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_ALUIMM = 7'b0010011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] F7_BASE    = 7'b0000000;

	typedef enum logic [2:0] {
		FMT_NONE = 3'd0,
		FMT_R    = 3'd1,
		FMT_I    = 3'd2,
		FMT_S    = 3'd3,
		FMT_B    = 3'd4,
		FMT_J    = 3'd5
	} fmt_t;

	typedef enum logic [4:0] {
		OP_NONE  = 5'd0,
		OP_ADD   = 5'd1,
		OP_LB    = 5'd2,
		OP_LH    = 5'd3,
		OP_LW    = 5'd4,
		OP_LBU   = 5'd5,
		OP_LHU   = 5'd6,
		OP_ADDI  = 5'd7,
		OP_SLTI  = 5'd8,
		OP_SLTIU = 5'd9,
		OP_XORI  = 5'd10,
		OP_ORI   = 5'd11,
		OP_ANDI  = 5'd12,
		OP_JALR  = 5'd13,
		OP_BEQ   = 5'd14,
		OP_BGE   = 5'd15,
		OP_SW    = 5'd16,
		OP_JAL   = 5'd17
	} op_t;

	// packed from the lowest bit up: format, op, rd, rs1, rs2, immediate
	typedef struct packed {
		logic [ImmW-1:0] immediate;
		logic [4:0]      src2_reg;
		logic [4:0]      src1_reg;
		logic [4:0]      dest_reg;
		op_t             op_code;
		fmt_t            format_kind;
	} result_t;

endpackage
`default_nettype wire

/* src/rv32i_subset_instruction_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_subset_instruction_decoder
// Decodes one RV32I subset instruction word per beat into format, op code,
// register indices and the raw unsigned immediate.
// ----------------------------------------------------------------------------
// channel   dir  width  fields
// s_*       in   32     instr_word
// m_*       out  48     format_kind, op_code, dest_reg, src1_reg, src2_reg,
//                       immediate
//
// One beat per cycle sustained while m_tready stays high; the word is held in
// the input register, then decoded into the result register.
// arst_n clears both stage valids; no item is held across reset.
// A stall on m_tready holds the result and backs up one stage at a time.
// ----------------------------------------------------------------------------
module rv32i_subset_instruction_decoder
	import rvdec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [InstrW-1:0] s_tdata,  // instr_word[31:0]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OutW-1:0]        m_tdata   // format_kind[2:0], op_code[7:3],
	                                         // dest_reg[12:8], src1_reg[17:13],
	                                         // src2_reg[22:18], immediate[43:23]
);

	logic              vld_s1;
	logic [InstrW-1:0] word_s1;
	logic              vld_s2;
	result_t           res_s2;
	result_t           dec;
	logic              adv_s2;

	assign adv_s2   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s2;

	always_comb begin
		logic [6:0] opc;
		logic [2:0] f3;
		opc = word_s1[6:0];
		f3  = word_s1[14:12];
		dec = '0;
		case (opc)
			OPC_REG: begin
				dec.format_kind = FMT_R;
				dec.dest_reg    = word_s1[11:7];
				dec.src1_reg    = word_s1[19:15];
				dec.src2_reg    = word_s1[24:20];
				if (word_s1[31:25] == F7_BASE && f3 == 3'd0) begin
					dec.op_code = OP_ADD;
				end
			end
			OPC_LOAD, OPC_ALUIMM, OPC_JALR: begin
				dec.format_kind = FMT_I;
				dec.dest_reg    = word_s1[11:7];
				dec.src1_reg    = word_s1[19:15];
				dec.immediate   = {9'd0, word_s1[31:20]};
				if (opc == OPC_LOAD) begin
					case (f3)
						3'd0:    dec.op_code = OP_LB;
						3'd1:    dec.op_code = OP_LH;
						3'd2:    dec.op_code = OP_LW;
						3'd4:    dec.op_code = OP_LBU;
						3'd5:    dec.op_code = OP_LHU;
						default: dec.op_code = OP_NONE;
					endcase
				end else if (opc == OPC_ALUIMM) begin
					case (f3)
						3'd0:    dec.op_code = OP_ADDI;
						3'd2:    dec.op_code = OP_SLTI;
						3'd3:    dec.op_code = OP_SLTIU;
						3'd4:    dec.op_code = OP_XORI;
						3'd6:    dec.op_code = OP_ORI;
						3'd7:    dec.op_code = OP_ANDI;
						default: dec.op_code = OP_NONE;
					endcase
				end else if (f3 == 3'd0) begin
					dec.op_code = OP_JALR;
				end
			end
			OPC_STORE: begin
				dec.format_kind = FMT_S;
				dec.src1_reg    = word_s1[19:15];
				dec.src2_reg    = word_s1[24:20];
				dec.immediate   = {9'd0, word_s1[31:25], word_s1[11:7]};
				if (f3 == 3'd2) begin
					dec.op_code = OP_SW;
				end
			end
			OPC_BRANCH: begin
				dec.format_kind = FMT_B;
				dec.src1_reg    = word_s1[19:15];
				dec.src2_reg    = word_s1[24:20];
				dec.immediate   = {8'd0, word_s1[31], word_s1[7], word_s1[30:25],
				                   word_s1[11:8], 1'b0};
				if (f3 == 3'd0) begin
					dec.op_code = OP_BEQ;
				end else if (f3 == 3'd5) begin
					dec.op_code = OP_BGE;
				end
			end
			OPC_JAL: begin
				dec.format_kind = FMT_J;
				dec.op_code     = OP_JAL;
				dec.dest_reg    = word_s1[11:7];
				dec.immediate   = {word_s1[31], word_s1[19:12], word_s1[20],
				                   word_s1[30:21], 1'b0};
			end
			default: begin
				dec = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata;
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= dec;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(OutW-ResW){1'b0}}, res_s2};

endmodule
`default_nettype wire

/* src/rvdec_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rvdec_checker
	import rvdec_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OutW-1:0]   m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed under stall");

	a_fmt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= FMT_J && m_tdata[7:3] <= OP_JAL
		&& m_tdata[OutW-1:ResW] == '0)
		else $error("format or op code out of range");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == FMT_NONE |-> m_tdata[ResW-1:3] == '0)
		else $error("unknown opcode with nonzero fields");

	a_r_no_imm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == FMT_R |-> m_tdata[43:23] == '0)
		else $error("R format with nonzero immediate");

endmodule

bind rv32i_subset_instruction_decoder rvdec_checker u_rvdec_checker (.*);
`default_nettype wire

/* bench/rv32i_subset_instruction_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_subset_instruction_decoder_tb
// Drives instruction words into the decoder and checks every result beat
// against an in-bench decode of the same word or a typed-in table result.
// A short table covers each instruction, the uncovered funct3/funct7 codes
// and the field extremes. A random part follows, mostly with known opcodes.
// Sender gaps, receiver stalls and one long receiver hold-off are mixed in.
// ----------------------------------------------------------------------------
module rv32i_subset_instruction_decoder_tb;
	import rvdec_pkg::*;

	localparam int CYCLE_LIMIT   = 200_000;
	localparam int NUM_DIRECTED  = 26;
	localparam int RANDOM_PER_PH = 440;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 8;

	localparam logic [6:0] F7_ALT   = 7'b0100000;
	localparam logic [2:0] F3_ADD   = 3'd0;
	localparam logic [2:0] F3_LB    = 3'd0;
	localparam logic [2:0] F3_LH    = 3'd1;
	localparam logic [2:0] F3_LW    = 3'd2;
	localparam logic [2:0] F3_LD    = 3'd3;
	localparam logic [2:0] F3_LBU   = 3'd4;
	localparam logic [2:0] F3_LHU   = 3'd5;
	localparam logic [2:0] F3_ADDI  = 3'd0;
	localparam logic [2:0] F3_SLLI  = 3'd1;
	localparam logic [2:0] F3_SLTI  = 3'd2;
	localparam logic [2:0] F3_SLTIU = 3'd3;
	localparam logic [2:0] F3_XORI  = 3'd4;
	localparam logic [2:0] F3_ORI   = 3'd6;
	localparam logic [2:0] F3_ANDI  = 3'd7;
	localparam logic [2:0] F3_JALR  = 3'd0;
	localparam logic [2:0] F3_SB    = 3'd0;
	localparam logic [2:0] F3_SW    = 3'd2;
	localparam logic [2:0] F3_BEQ   = 3'd0;
	localparam logic [2:0] F3_BNE   = 3'd1;
	localparam logic [2:0] F3_BGE   = 3'd5;

	typedef struct {
		logic [31:0] word;
		bit          typed;
		result_t     want;
	} directed_row_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [InstrW-1:0] s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OutW-1:0]   m_tdata;

	result_t       decoded_q[$];
	directed_row_t directed_rows [NUM_DIRECTED];
	int            mismatches   = 0;
	int            cycles       = 0;
	int            tx_idle_pct  = 0;
	int            rx_stall_pct = 0;
	bit            start_hold   = 1'b0;
	logic          hold_rx      = 1'b0;

	rv32i_subset_instruction_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[rv32i_subset_instruction_decoder] ERROR");
			$finish;
		end
	end

	function automatic result_t decode_word(input logic [31:0] w);
		result_t    r;
		logic [2:0] f3;
		r  = '0;
		f3 = w[14:12];
		case (w[6:0])
			OPC_REG: begin
				r.format_kind = FMT_R;
				r.dest_reg    = w[11:7];
				r.src1_reg    = w[19:15];
				r.src2_reg    = w[24:20];
				if (w[31:25] == F7_BASE && f3 == F3_ADD)
					r.op_code = OP_ADD;
			end
			OPC_LOAD, OPC_ALUIMM, OPC_JALR: begin
				r.format_kind = FMT_I;
				r.dest_reg    = w[11:7];
				r.src1_reg    = w[19:15];
				r.immediate   = {9'd0, w[31:20]};
				if (w[6:0] == OPC_LOAD) begin
					case (f3)
						F3_LB:   r.op_code = OP_LB;
						F3_LH:   r.op_code = OP_LH;
						F3_LW:   r.op_code = OP_LW;
						F3_LBU:  r.op_code = OP_LBU;
						F3_LHU:  r.op_code = OP_LHU;
						default: r.op_code = OP_NONE;
					endcase
				end else if (w[6:0] == OPC_ALUIMM) begin
					case (f3)
						F3_ADDI:  r.op_code = OP_ADDI;
						F3_SLTI:  r.op_code = OP_SLTI;
						F3_SLTIU: r.op_code = OP_SLTIU;
						F3_XORI:  r.op_code = OP_XORI;
						F3_ORI:   r.op_code = OP_ORI;
						F3_ANDI:  r.op_code = OP_ANDI;
						default:  r.op_code = OP_NONE;
					endcase
				end else if (f3 == F3_JALR) begin
					r.op_code = OP_JALR;
				end
			end
			OPC_STORE: begin
				r.format_kind = FMT_S;
				r.src1_reg    = w[19:15];
				r.src2_reg    = w[24:20];
				r.immediate   = {9'd0, w[31:25], w[11:7]};
				if (f3 == F3_SW)
					r.op_code = OP_SW;
			end
			OPC_BRANCH: begin
				r.format_kind = FMT_B;
				r.src1_reg    = w[19:15];
				r.src2_reg    = w[24:20];
				r.immediate   = {8'd0, w[31], w[7], w[30:25], w[11:8], 1'b0};
				if (f3 == F3_BEQ)
					r.op_code = OP_BEQ;
				else if (f3 == F3_BGE)
					r.op_code = OP_BGE;
			end
			OPC_JAL: begin
				r.format_kind = FMT_J;
				r.dest_reg    = w[11:7];
				r.immediate   = {w[31], w[19:12], w[20], w[30:21], 1'b0};
				r.op_code     = OP_JAL;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// sampled at the falling edge; the beat is taken at the next rising edge
	always @(negedge clk) begin : result_monitor
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[ResW-1:0];
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got %h", $time, got);
				mismatches++;
			end else begin
				want = decoded_q.pop_front();
				check_field("format_kind", want.format_kind, got.format_kind);
				check_field("op_code", want.op_code, got.op_code);
				check_field("dest_reg", want.dest_reg, got.dest_reg);
				check_field("src1_reg", want.src1_reg, got.src1_reg);
				check_field("src2_reg", want.src2_reg, got.src2_reg);
				check_field("immediate", want.immediate, got.immediate);
			end
		end
	end

	always @(posedge clk)
		m_tready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);

	initial begin : rx_hold_off
		wait (start_hold);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// called and returns at a rising edge; s_tvalid stays high on return
	task automatic send_word(input logic [31:0] w, input result_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(negedge clk); while (!s_tready);
		decoded_q.push_back(want);
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] w;
		directed_rows = '{
			'{32'h0000_0000, 1'b1, '0},
			'{32'hFFFF_FFFF, 1'b1, '0},
			'{{F7_BASE, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_REG}, 1'b1,
				'{21'd0, 5'd31, 5'd31, 5'd31, OP_ADD, FMT_R}},
			'{{F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_REG}, 1'b0, '0},
			'{{12'h000, 5'd0, F3_LB, 5'd0, OPC_LOAD}, 1'b0, '0},
			'{{12'h800, 5'd1, F3_LH, 5'd2, OPC_LOAD}, 1'b0, '0},
			'{{12'h7FF, 5'd3, F3_LW, 5'd4, OPC_LOAD}, 1'b0, '0},
			'{{12'h123, 5'd5, F3_LBU, 5'd6, OPC_LOAD}, 1'b0, '0},
			'{{12'hABC, 5'd7, F3_LHU, 5'd8, OPC_LOAD}, 1'b0, '0},
			'{{12'h555, 5'd9, F3_LD, 5'd10, OPC_LOAD}, 1'b0, '0},
			'{{12'hFFF, 5'd31, F3_ADDI, 5'd31, OPC_ALUIMM}, 1'b1,
				'{21'h000FFF, 5'd0, 5'd31, 5'd31, OP_ADDI, FMT_I}},
			'{{12'h001, 5'd11, F3_SLTI, 5'd12, OPC_ALUIMM}, 1'b0, '0},
			'{{12'hFFE, 5'd13, F3_SLTIU, 5'd14, OPC_ALUIMM}, 1'b0, '0},
			'{{12'h0F0, 5'd15, F3_XORI, 5'd16, OPC_ALUIMM}, 1'b0, '0},
			'{{12'hA5A, 5'd17, F3_ORI, 5'd18, OPC_ALUIMM}, 1'b0, '0},
			'{{12'h5A5, 5'd19, F3_ANDI, 5'd20, OPC_ALUIMM}, 1'b0, '0},
			'{{12'h01F, 5'd21, F3_SLLI, 5'd22, OPC_ALUIMM}, 1'b0, '0},
			'{{12'h004, 5'd1, F3_JALR, 5'd0, OPC_JALR}, 1'b0, '0},
			'{{12'hFFF, 5'd2, F3_BNE, 5'd3, OPC_JALR}, 1'b0, '0},
			'{{7'h7F, 5'd31, 5'd31, F3_SW, 5'h1F, OPC_STORE}, 1'b1,
				'{21'h000FFF, 5'd31, 5'd31, 5'd0, OP_SW, FMT_S}},
			'{{7'h00, 5'd1, 5'd2, F3_SB, 5'd3, OPC_STORE}, 1'b0, '0},
			'{{7'h7F, 5'd31, 5'd31, F3_BGE, 5'h1F, OPC_BRANCH}, 1'b1,
				'{21'h001FFE, 5'd31, 5'd31, 5'd0, OP_BGE, FMT_B}},
			'{{7'h40, 5'd4, 5'd5, F3_BEQ, 5'h01, OPC_BRANCH}, 1'b0, '0},
			'{{7'h3F, 5'd6, 5'd7, F3_BNE, 5'h1E, OPC_BRANCH}, 1'b0, '0},
			'{{20'hFFFFF, 5'd31, OPC_JAL}, 1'b1,
				'{21'h1FFFFE, 5'd0, 5'd0, 5'd31, OP_JAL, FMT_J}},
			'{{20'h80123, 5'd1, OPC_JAL}, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed ?
				directed_rows[i].want : decode_word(directed_rows[i].word));

		// phases: none, sender gaps, receiver stalls, both, long hold-off
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1:       begin tx_idle_pct = 85; rx_stall_pct = 0;  end
				2:       begin tx_idle_pct = 0;  rx_stall_pct = 85; end
				3:       begin tx_idle_pct = 31; rx_stall_pct = 31; end
				default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			endcase
			if (ph == 4)
				start_hold = 1'b1;
			repeat (ph == 4 ? 150 : RANDOM_PER_PH) begin
				w = $urandom();
				if ($urandom_range(99) < 75) begin
					case ($urandom_range(6))
						0:       w[6:0] = OPC_REG;
						1:       w[6:0] = OPC_LOAD;
						2:       w[6:0] = OPC_ALUIMM;
						3:       w[6:0] = OPC_JALR;
						4:       w[6:0] = OPC_BRANCH;
						5:       w[6:0] = OPC_STORE;
						default: w[6:0] = OPC_JAL;
					endcase
					if (w[6:0] == OPC_REG && $urandom_range(1) == 1)
						w[31:25] = F7_BASE;
				end
				send_word(w, decode_word(w));
			end
		end
		s_tvalid <= 1'b0;

		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[rv32i_subset_instruction_decoder] OK");
		else
			$display("[rv32i_subset_instruction_decoder] ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/rvdec_pkg.sv
src/rv32i_subset_instruction_decoder.sv
src/rvdec_checker.sv
bench/rv32i_subset_instruction_decoder_tb.sv
